// ===== src/scl_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// scl_pkg
// Shared types and character codes for the source comment locator.
// ---------------------------------------------------------------------------
package scl_pkg;

   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;

   localparam int OUT_OFFSET_WIDTH = 24;
   localparam int OUT_POS_WIDTH    = 16;

   localparam logic KIND_LINE  = 1'b0;
   localparam logic KIND_BLOCK = 1'b1;

   // scanner states, one-hot
   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_SLASH     = 9'b000000010,
      ST_LINE_CMT  = 9'b000000100,
      ST_BLOCK_CMT = 9'b000001000,
      ST_BLOCK_STAR= 9'b000010000,
      ST_DQ_LIT    = 9'b000100000,
      ST_SQ_LIT    = 9'b001000000,
      ST_DQ_ESC    = 9'b010000000,
      ST_SQ_ESC    = 9'b100000000
   } scan_state_type;

   typedef struct packed {
      logic [OUT_POS_WIDTH-1:0]    end_column;
      logic [OUT_POS_WIDTH-1:0]    end_line;
      logic [OUT_POS_WIDTH-1:0]    start_column;
      logic [OUT_POS_WIDTH-1:0]    start_line;
      logic [OUT_OFFSET_WIDTH-1:0] end_offset;
      logic [OUT_OFFSET_WIDTH-1:0] start_offset;
      logic                        comment_kind;
   } result_type;

endpackage
`default_nettype wire

// ===== src/source_comment_locator.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// source_comment_locator
// Finds line and block comments in a byte stream of C-like source text.
// ---------------------------------------------------------------------------
// Takes one source byte per request and one response per closed comment.
// A line comment runs from "//" to the next newline; a block comment from
// "/*" to the slash of the next "*/". Quoted literals (double and single,
// with backslash escapes) are skipped. A byte flagged covered on req_tuser
// sends the scanner back to idle and only moves the position. Each response
// gives the kind on rsp_tuser and the start/end offset, line and column on
// rsp_tdata. Offsets wrap at 2^OFFSET_WIDTH; line and column saturate at
// 2^LINE_WIDTH-1 and are cut or zero-extended to the 24/16-bit fields.
// Rate: one byte per cycle while req_tready is high; responses are registered.
// The scanner update is a single registered step; a two-entry response buffer
// (output register plus skid entry) keeps req_tready high while one response
// waits, and drops it only when both entries are full.
// ---------------------------------------------------------------------------
module source_comment_locator
   import scl_pkg::*;
#(
   parameter int OFFSET_WIDTH = 24,
   parameter int LINE_WIDTH   = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] char_code
   input  wire logic         req_tuser,   // [0] covered
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [23:0] start_offset, [47:24] end_offset, [63:48] start_line,
   // [79:64] start_column, [95:80] end_line, [111:96] end_column
   output logic [111:0]      rsp_tdata,
   output logic              rsp_tuser    // [0] comment_kind
);

   localparam logic [LINE_WIDTH-1:0] POS_MAX = {LINE_WIDTH{1'b1}};

   scan_state_type          state_ff, state_in;
   logic [OFFSET_WIDTH-1:0] cur_offset_ff, cur_offset_in;
   logic [LINE_WIDTH-1:0]   cur_line_ff, cur_line_in;
   logic [LINE_WIDTH-1:0]   cur_column_ff, cur_column_in;
   logic [OFFSET_WIDTH-1:0] open_offset_ff, open_offset_in;
   logic [LINE_WIDTH-1:0]   open_line_ff, open_line_in;
   logic [LINE_WIDTH-1:0]   open_column_ff, open_column_in;

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;

   logic       accept;
   logic       pop;
   logic       emit;
   logic       emit_kind;
   logic [7:0] ch;
   logic       is_nl;
   result_type result;
   logic [63:0] start_off_ext, end_off_ext;
   logic [63:0] start_line_ext, start_col_ext, end_line_ext, end_col_ext;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign ch         = req_tdata;
   assign is_nl      = (ch == CH_NL);

   // scanner step
   always_comb begin
      state_in       = state_ff;
      open_offset_in = open_offset_ff;
      open_line_in   = open_line_ff;
      open_column_in = open_column_ff;
      emit           = 1'b0;
      emit_kind      = KIND_LINE;
      if (req_tuser) begin
         state_in = ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (ch == CH_SLASH) begin
                  state_in       = ST_SLASH;
                  open_offset_in = cur_offset_ff;
                  open_line_in   = cur_line_ff;
                  open_column_in = cur_column_ff;
               end else if (ch == CH_DQUOTE) begin
                  state_in = ST_DQ_LIT;
               end else if (ch == CH_SQUOTE) begin
                  state_in = ST_SQ_LIT;
               end
            end
            ST_SLASH: begin
               if (ch == CH_SLASH)     state_in = ST_LINE_CMT;
               else if (ch == CH_STAR) state_in = ST_BLOCK_CMT;
               else                    state_in = ST_IDLE;
            end
            ST_LINE_CMT: begin
               if (is_nl) begin
                  emit      = 1'b1;
                  emit_kind = KIND_LINE;
                  state_in  = ST_IDLE;
               end
            end
            ST_BLOCK_CMT: begin
               if (ch == CH_STAR) state_in = ST_BLOCK_STAR;
            end
            ST_BLOCK_STAR: begin
               if (ch == CH_SLASH) begin
                  emit      = 1'b1;
                  emit_kind = KIND_BLOCK;
                  state_in  = ST_IDLE;
               end else if (ch != CH_STAR) begin
                  state_in = ST_BLOCK_CMT;
               end
            end
            ST_DQ_LIT: begin
               if (ch == CH_DQUOTE)       state_in = ST_IDLE;
               else if (ch == CH_BSLASH)  state_in = ST_DQ_ESC;
            end
            ST_SQ_LIT: begin
               if (ch == CH_SQUOTE)       state_in = ST_IDLE;
               else if (ch == CH_BSLASH)  state_in = ST_SQ_ESC;
            end
            ST_DQ_ESC: state_in = ST_DQ_LIT;
            ST_SQ_ESC: state_in = ST_SQ_LIT;
            default:   state_in = ST_IDLE;
         endcase
      end
   end

   // position tracking: newline bumps line, column restarts at 1
   always_comb begin
      cur_offset_in = cur_offset_ff + OFFSET_WIDTH'(1);
      cur_line_in   = cur_line_ff;
      if (is_nl) begin
         if (cur_line_ff != POS_MAX) cur_line_in = cur_line_ff + LINE_WIDTH'(1);
         cur_column_in = LINE_WIDTH'(1);
      end else if (cur_column_ff != POS_MAX) begin
         cur_column_in = cur_column_ff + LINE_WIDTH'(1);
      end else begin
         cur_column_in = cur_column_ff;
      end
   end

   // response fields, fitted to the fixed port widths
   assign start_off_ext  = 64'(open_offset_ff);
   assign end_off_ext    = 64'(cur_offset_ff);
   assign start_line_ext = 64'(open_line_ff);
   assign start_col_ext  = 64'(open_column_ff);
   assign end_line_ext   = 64'(cur_line_ff);
   assign end_col_ext    = 64'(cur_column_ff);

   always_comb begin
      result.comment_kind = emit_kind;
      result.start_offset = start_off_ext[OUT_OFFSET_WIDTH-1:0];
      result.end_offset   = end_off_ext[OUT_OFFSET_WIDTH-1:0];
      result.start_line   = start_line_ext[OUT_POS_WIDTH-1:0];
      result.start_column = start_col_ext[OUT_POS_WIDTH-1:0];
      result.end_line     = end_line_ext[OUT_POS_WIDTH-1:0];
      result.end_column   = end_col_ext[OUT_POS_WIDTH-1:0];
   end

   // output register plus skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_in = accept && emit;
         if (accept && emit) out_data_in = result;
      end else if (accept && emit) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cur_offset_ff  <= '0;
         cur_line_ff    <= '0;
         cur_column_ff  <= '0;
         open_offset_ff <= '0;
         open_line_ff   <= '0;
         open_column_ff <= '0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            state_ff       <= state_in;
            cur_offset_ff  <= cur_offset_in;
            cur_line_ff    <= cur_line_in;
            cur_column_ff  <= cur_column_in;
            open_offset_ff <= open_offset_in;
            open_line_ff   <= open_line_in;
            open_column_ff <= open_column_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_data_ff.comment_kind;
   assign rsp_tdata  = {out_data_ff.end_column, out_data_ff.end_line,
                        out_data_ff.start_column, out_data_ff.start_line,
                        out_data_ff.end_offset, out_data_ff.start_offset};

endmodule
`default_nettype wire
